// ===== rtl/core/lmfr_pkg.sv =====
// Shared types, constants and helpers of the LED matrix frame refresh unit.
package lmfr_pkg;

	localparam int MAX_DEVICES_DEF = 4;
	localparam int ROWS = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] DEVICE_COUNT_RST = 3'd4;
	localparam logic [7:0] NOOP_BYTE = 8'h00;

	localparam logic [2:0] OP_SET_PIXEL = 3'd0;
	localparam logic [2:0] OP_CLEAR     = 3'd1;
	localparam logic [2:0] OP_DRAW      = 3'd2;
	localparam logic [2:0] OP_BCAST     = 3'd3;
	localparam logic [2:0] OP_WRITE_ONE = 3'd4;
	localparam logic [2:0] OP_SET_ROW   = 3'd5;

	typedef enum logic [2:0] {
		K_PIX,
		K_CLR,
		K_DRAW,
		K_BCAST,
		K_ONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       pixel_on;
		logic [7:0] x;
		logic [2:0] y;
		logic [7:0] idx;
		logic [7:0] addr;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] word_addr;
		logic [7:0] word_data;
		logic       frame_end;
		logic       last;
	} out_word_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PIX_WR,
		BK_WORDS
	} back_state_t;

	function automatic logic [7:0] mirror8(input logic [7:0] v);
		logic [7:0] m;
		for (int b = 0; b < 8; b++) begin
			m[7 - b] = v[b];
		end
		return m;
	endfunction

endpackage

// ===== rtl/core/lmfr_front.sv =====
// Front end: accepts commands, drops those that do nothing and classifies the rest.
module lmfr_front import lmfr_pkg::*; #(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF,
	localparam int CNT_W = $clog2(MAX_DEVICES + 1)
) (
	input  logic             start,
	input  logic             full,
	input  logic [CNT_W-1:0] n,
	input  logic [2:0]       op,
	input  logic [7:0]       x,
	input  logic [7:0]       y,
	input  logic             pixel_on,
	input  logic [7:0]       device_index,
	input  logic [7:0]       reg_addr,
	input  logic [7:0]       reg_data,
	input  logic [7:0]       row,
	output logic             push,
	output cmd_t             cmd
);

	localparam int COLS = 8 * MAX_DEVICES;

	logic keep;
	logic chain_ok;

	assign chain_ok = (n != '0);

	always_comb begin
		keep          = 1'b0;
		cmd.kind      = K_CLR;
		cmd.pixel_on  = pixel_on;
		cmd.x         = x;
		cmd.y         = y[2:0];
		cmd.idx       = device_index;
		cmd.addr      = reg_addr;
		cmd.data      = reg_data;
		unique case (op)
			OP_SET_PIXEL: begin
				cmd.kind = K_PIX;
				keep     = (x < 8'(COLS)) && (y < 8'(ROWS));
			end
			OP_CLEAR: begin
				cmd.kind = K_CLR;
				keep     = 1'b1;
			end
			OP_DRAW: begin
				cmd.kind = K_DRAW;
				keep     = chain_ok;
			end
			OP_BCAST: begin
				cmd.kind = K_BCAST;
				keep     = chain_ok;
			end
			OP_WRITE_ONE: begin
				cmd.kind = K_ONE;
				keep     = device_index < 8'(n);
			end
			OP_SET_ROW: begin
				cmd.kind = K_BCAST;
				cmd.addr = row;
				keep     = chain_ok && (row >= 8'd1) && (row <= 8'(ROWS));
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = start && !full && keep;

endmodule

// ===== rtl/core/lmfr_queue.sv =====
// Short command queue between the front end and the word sequencer.
module lmfr_queue import lmfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic q_valid,
	output cmd_t q_cmd,
	output logic full
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_cmd   = slot_q[rptr_q];
	assign full    = (cnt_q == CW'(QUEUE_DEPTH));

endmodule

// ===== rtl/core/lmfr_back.sv =====
// Back end: frame buffer and word sequencer that carries out queued commands.
module lmfr_back import lmfr_pkg::*; #(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF,
	localparam int CNT_W = $clog2(MAX_DEVICES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] n,
	input  logic             q_valid,
	input  cmd_t             q_cmd,
	output logic             pop,
	output logic             strobe,
	output out_word_t        word
);

	localparam int DEPTH = ROWS * MAX_DEVICES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

	back_state_t state_q, state_d;
	cmd_t        cmd_q, cmd_d;
	logic [IDX_W-1:0] i_q, i_d;
	logic [2:0]  r_q, r_d;

	logic [7:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]    rd_s1;
	logic          rd_vld_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;
	logic          clr;
	logic [7:0]    old_byte;
	logic [7:0]    mask;

	logic          emit;
	logic [7:0]    w_addr;
	logic [7:0]    w_data;
	logic          w_mem;
	logic          w_fe;
	logic          w_last;

	logic          strobe_s1;
	logic [7:0]    addr_s1;
	logic [7:0]    data_s1;
	logic          mem_s1;
	logic          fe_s1;
	logic          last_s1;

	function automatic logic [AW-1:0] pix_entry(input cmd_t c);
		return AW'(AW'(c.y) * AW'(MAX_DEVICES) + AW'(c.x[7:3]));
	endfunction

	assign old_byte = rd_vld_s1 ? rd_s1 : NOOP_BYTE;
	assign mask     = 8'h80 >> cmd_q.x[2:0];
	assign wa       = pix_entry(cmd_q);
	assign wd       = cmd_q.pixel_on ? (old_byte | mask) : (old_byte & ~mask);

	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		i_d     = i_q;
		r_d     = r_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		we      = 1'b0;
		clr     = 1'b0;
		emit    = 1'b0;
		w_addr  = NOOP_BYTE;
		w_data  = NOOP_BYTE;
		w_mem   = 1'b0;
		w_fe    = 1'b0;
		w_last  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop   = 1'b1;
					cmd_d = q_cmd;
					i_d   = IDX_W'(n - 1'b1);
					r_d   = '0;
					unique case (q_cmd.kind)
						K_CLR: begin
							clr = 1'b1;
						end
						K_PIX: begin
							rd_en   = 1'b1;
							rd_addr = pix_entry(q_cmd);
							state_d = BK_PIX_WR;
						end
						default: begin
							state_d = BK_WORDS;
						end
					endcase
				end
			end
			BK_PIX_WR: begin
				we      = 1'b1;
				state_d = BK_IDLE;
			end
			BK_WORDS: begin
				emit   = 1'b1;
				w_fe   = (i_q == '0);
				w_last = (i_q == '0) && ((cmd_q.kind != K_DRAW) || (r_q == 3'(ROWS - 1)));
				if (cmd_q.kind == K_DRAW) begin
					w_addr  = 8'(r_q) + 8'd1;
					w_mem   = 1'b1;
					rd_en   = 1'b1;
					rd_addr = AW'(AW'(3'(ROWS - 1) - r_q) * AW'(MAX_DEVICES) + AW'(i_q));
				end else if ((cmd_q.kind == K_ONE) && (8'(i_q) != cmd_q.idx)) begin
					w_addr = NOOP_BYTE;
					w_data = NOOP_BYTE;
				end else begin
					w_addr = cmd_q.addr;
					w_data = cmd_q.data;
				end
				if (i_q == '0) begin
					if ((cmd_q.kind == K_DRAW) && (r_q != 3'(ROWS - 1))) begin
						r_d = 3'(r_q + 1'b1);
						i_d = IDX_W'(n - 1'b1);
					end else begin
						state_d = BK_IDLE;
					end
				end else begin
					i_d = IDX_W'(i_q - 1'b1);
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		i_q   <= i_d;
		r_q   <= r_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= w_addr;
		data_s1 <= w_data;
		mem_s1  <= w_mem;
		fe_s1   <= w_fe;
		last_s1 <= w_last;
	end

	assign strobe         = strobe_s1;
	assign word.word_addr = addr_s1;
	assign word.word_data = mem_s1 ? (rd_vld_s1 ? mirror8(rd_s1) : NOOP_BYTE) : data_s1;
	assign word.frame_end = fe_s1;
	assign word.last      = last_s1;

endmodule

// ===== rtl/core/led_matrix_frame_refresh_unit.sv =====
// Top level of the LED matrix frame refresh unit.
// A command is taken when start is high and busy is low; busy rises only while the
// two-entry command queue is full. Queued commands run in order in the word
// sequencer: a pixel write reads, then writes, the buffer byte; a clear is done
// as it is taken from the queue; and a draw, broadcast, single write or row write
// is taken from the queue and then emits its words one per cycle (8*n words for
// a draw, n otherwise, n the saturated module count). Words appear in the cycle
// after they are sequenced, each on the word ports for exactly one cycle
// with strobe high; the receiver cannot stall them, and the words of one command
// come in consecutive cycles. Commands that cause nothing are dropped at the
// front. The buffer clears at reset and on a clear command.
module led_matrix_frame_refresh_unit import lmfr_pkg::*; #(
	parameter int MAX_DEVICES = MAX_DEVICES_DEF,
	localparam int CNT_W = $clog2(MAX_DEVICES + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] op,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic       pixel_on,
	input  logic [7:0] device_index,
	input  logic [7:0] reg_addr,
	input  logic [7:0] reg_data,
	input  logic [7:0] row,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data,
	output logic       strobe,
	output logic [7:0] word_addr,
	output logic [7:0] word_data,
	output logic       frame_end,
	output logic       last
);

	logic [2:0]       dev_count_q;
	logic [CNT_W-1:0] n;
	logic             full;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	logic             q_valid;
	cmd_t             q_cmd;
	out_word_t        word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= DEVICE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			dev_count_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign n = (4'(dev_count_q) > 4'(MAX_DEVICES)) ? CNT_W'(MAX_DEVICES) : CNT_W'(dev_count_q);

	lmfr_front #(.MAX_DEVICES(MAX_DEVICES)) u_front (
		.start        (start),
		.full         (full),
		.n            (n),
		.op           (op),
		.x            (x),
		.y            (y),
		.pixel_on     (pixel_on),
		.device_index (device_index),
		.reg_addr     (reg_addr),
		.reg_data     (reg_data),
		.row          (row),
		.push         (push),
		.cmd          (push_cmd)
	);

	lmfr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.full     (full)
	);

	lmfr_back #(.MAX_DEVICES(MAX_DEVICES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.n       (n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.strobe  (strobe),
		.word    (word)
	);

	assign busy      = full;
	assign word_addr = word.word_addr;
	assign word_data = word.word_data;
	assign frame_end = word.frame_end;
	assign last      = word.last;

`ifndef ASSERT_OFF
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> frame_end)
		else $error("final word of a command does not end a frame");

	a_words_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside the words of one command");

	a_busy_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_valid)
		else $error("busy with an empty command queue");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for the LED matrix frame refresh unit: directed table, then random commands.
`timescale 1ns / 1ps

module testbench import lmfr_pkg::*;;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int BUF_BYTES = ROWS * MAX_DEVICES_DEF;
	localparam int BUF_COLS = 8 * MAX_DEVICES_DEF;
	localparam int SETTLE = 12;
	localparam int PHASE_ITEMS = 58;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] x;
		logic [7:0] y;
		logic       on;
		logic [7:0] idx;
		logic [7:0] addr;
		logic [7:0] data;
		logic [7:0] row;
	} lm_cmd_t;

	typedef struct {
		lm_cmd_t    cmd;
		bit         typed;
		int         count;
		logic [7:0] addr;
		logic [7:0] data;
	} plan_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] op;
	logic [7:0] x;
	logic [7:0] y;
	logic       pixel_on;
	logic [7:0] device_index;
	logic [7:0] reg_addr;
	logic [7:0] reg_data;
	logic [7:0] row;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_data;
	logic       strobe;
	logic [7:0] word_addr;
	logic [7:0] word_data;
	logic       frame_end;
	logic       last;

	logic [7:0] pixels [BUF_BYTES];
	logic [2:0] chain_cfg;
	out_word_t  due_words [$];
	int         bad_words;
	bit         idle_on;

	led_matrix_frame_refresh_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.x            (x),
		.y            (y),
		.pixel_on     (pixel_on),
		.device_index (device_index),
		.reg_addr     (reg_addr),
		.reg_data     (reg_data),
		.row          (row),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.word_addr    (word_addr),
		.word_data    (word_data),
		.frame_end    (frame_end),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic int chain_len();
		return (chain_cfg > MAX_DEVICES_DEF) ? MAX_DEVICES_DEF : int'(chain_cfg);
	endfunction

	task automatic push_word(input logic [7:0] a, input logic [7:0] d, input logic fe);
		due_words.push_back('{word_addr: a, word_data: d, frame_end: fe, last: 1'b0});
	endtask

	task automatic render_command(input lm_cmd_t c, output int pushed);
		int n;
		int first;
		logic [7:0] src;
		logic [7:0] flip;
		n = chain_len();
		first = due_words.size();
		case (c.op)
			OP_SET_PIXEL: begin
				if (c.x < BUF_COLS && c.y < ROWS)
					pixels[c.y * MAX_DEVICES_DEF + c.x[7:3]][7 - c.x[2:0]] = c.on;
			end
			OP_CLEAR: begin
				foreach (pixels[i])
					pixels[i] = '0;
			end
			OP_DRAW: begin
				for (int r = 0; r < ROWS; r++) begin
					for (int i = n - 1; i >= 0; i--) begin
						src = pixels[(ROWS - 1 - r) * MAX_DEVICES_DEF + i];
						for (int b = 0; b < 8; b++)
							flip[7 - b] = src[b];
						push_word(8'(r + 1), flip, i == 0);
					end
				end
			end
			OP_BCAST: begin
				for (int i = 0; i < n; i++)
					push_word(c.addr, c.data, i == n - 1);
			end
			OP_WRITE_ONE: begin
				if (c.idx < n) begin
					for (int i = n - 1; i >= 0; i--) begin
						if (i == c.idx)
							push_word(c.addr, c.data, i == 0);
						else
							push_word(NOOP_BYTE, NOOP_BYTE, i == 0);
					end
				end
			end
			OP_SET_ROW: begin
				if (c.row >= 1 && c.row <= 8) begin
					for (int i = 0; i < n; i++)
						push_word(c.row, c.data, i == n - 1);
				end
			end
			default: begin
			end
		endcase
		pushed = due_words.size() - first;
		if (pushed > 0)
			due_words[due_words.size() - 1].last = 1'b1;
	endtask

	function automatic plan_row_t plan_row(input logic [2:0] o, input logic [7:0] px,
			input logic [7:0] py, input logic pon, input logic [7:0] pidx,
			input logic [7:0] pa, input logic [7:0] pd, input logic [7:0] pr,
			input bit typed, input int count, input logic [7:0] ta, input logic [7:0] td);
		plan_row_t p;
		p.cmd.op = o;
		p.cmd.x = px;
		p.cmd.y = py;
		p.cmd.on = pon;
		p.cmd.idx = pidx;
		p.cmd.addr = pa;
		p.cmd.data = pd;
		p.cmd.row = pr;
		p.typed = typed;
		p.count = count;
		p.addr = ta;
		p.data = td;
		return p;
	endfunction

	function automatic lm_cmd_t random_command();
		lm_cmd_t c;
		int pick;
		c.op = 3'($urandom_range(0, 7));
		c.x = 8'($urandom);
		c.y = 8'($urandom);
		c.on = 1'($urandom);
		c.idx = 8'($urandom);
		c.addr = 8'($urandom);
		c.data = 8'($urandom);
		c.row = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 34) begin
			c.op = OP_SET_PIXEL;
			if ($urandom_range(0, 9) != 0) begin
				c.x = 8'($urandom_range(0, BUF_COLS - 1));
				c.y = 8'($urandom_range(0, ROWS - 1));
			end
		end else if (pick < 49) begin
			c.op = OP_DRAW;
		end else if (pick < 59) begin
			c.op = OP_BCAST;
		end else if (pick < 71) begin
			c.op = OP_WRITE_ONE;
			if ($urandom_range(0, 6) != 0)
				c.idx = 8'($urandom_range(0, MAX_DEVICES_DEF));
		end else if (pick < 83) begin
			c.op = OP_SET_ROW;
			if ($urandom_range(0, 6) != 0)
				c.row = 8'($urandom_range(0, 9));
		end else if (pick < 88) begin
			c.op = OP_CLEAR;
		end else if (pick < 94) begin
			c.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
		end
		return c;
	endfunction

	task automatic issue(input lm_cmd_t c, output int pushed);
		start <= 1'b1;
		op <= c.op;
		x <= c.x;
		y <= c.y;
		pixel_on <= c.on;
		device_index <= c.idx;
		reg_addr <= c.addr;
		reg_data <= c.data;
		row <= c.row;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		render_command(c, pushed);
	endtask

	task automatic maybe_pause();
		if (idle_on && $urandom_range(0, 99) < 38) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_chain_len(input logic [2:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		chain_cfg = v;
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && strobe) begin
			if (due_words.size() == 0) begin
				if (bad_words < 10)
					$display("unexpected word: addr=%h data=%h frame_end=%b last=%b",
						word_addr, word_data, frame_end, last);
				bad_words++;
			end else begin
				want = due_words.pop_front();
				if (want.word_addr !== word_addr || want.word_data !== word_data ||
						want.frame_end !== frame_end || want.last !== last) begin
					if (bad_words < 10)
						$display({"word mismatch: expected addr=%h data=%h fe=%b last=%b,",
							" got addr=%h data=%h fe=%b last=%b"},
							want.word_addr, want.word_data, want.frame_end, want.last,
							word_addr, word_data, frame_end, last);
					bad_words++;
				end
			end
		end
	end

	initial begin
		plan_row_t  plan [$];
		logic [2:0] counts [8];
		int         pushed;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_SET_PIXEL;
		x <= '0;
		y <= '0;
		pixel_on <= 1'b0;
		device_index <= '0;
		reg_addr <= '0;
		reg_data <= '0;
		row <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		chain_cfg = DEVICE_COUNT_RST;
		foreach (pixels[i])
			pixels[i] = '0;
		bad_words = 0;
		idle_on = 1'b1;
		counts = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6};

		plan.push_back(plan_row(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 31, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 32, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 255, 255, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 5, 8, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 17, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 9, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_PIXEL, 17, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_BCAST, 0, 0, 0, 0, 8'h0C, 8'h01, 0, 1, 4, 8'h0C, 8'h01));
		plan.push_back(plan_row(OP_BCAST, 0, 0, 0, 0, 8'hFF, 8'hFF, 0, 1, 4, 8'hFF, 8'hFF));
		plan.push_back(plan_row(OP_WRITE_ONE, 0, 0, 0, 0, 8'h0A, 8'h0F, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_WRITE_ONE, 0, 0, 0, 3, 8'hFF, 8'h00, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_WRITE_ONE, 0, 0, 0, 4, 8'h0A, 8'h0F, 0, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_WRITE_ONE, 0, 0, 0, 255, 8'h0A, 8'h0F, 0, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_ROW, 0, 0, 0, 0, 0, 8'hA5, 1, 1, 4, 8'd1, 8'hA5));
		plan.push_back(plan_row(OP_SET_ROW, 0, 0, 0, 0, 0, 8'hFF, 8, 1, 4, 8'd8, 8'hFF));
		plan.push_back(plan_row(OP_SET_ROW, 0, 0, 0, 0, 0, 8'hFF, 0, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_ROW, 0, 0, 0, 0, 0, 8'hFF, 9, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_SET_ROW, 0, 0, 0, 0, 0, 8'hFF, 255, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_SPARE6, 31, 7, 1, 1, 8'h0C, 8'h01, 1, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_SPARE7, 255, 255, 1, 255, 8'hFF, 8'hFF, 255, 1, 0, 0, 0));
		plan.push_back(plan_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		plan.push_back(plan_row(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			issue(plan[i].cmd, pushed);
			if (plan[i].typed) begin
				repeat (pushed)
					void'(due_words.pop_back());
				for (int k = 0; k < plan[i].count; k++)
					push_word(plan[i].addr, plan[i].data, k == plan[i].count - 1);
				if (plan[i].count > 0)
					due_words[due_words.size() - 1].last = 1'b1;
			end
			maybe_pause();
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_chain_len(counts[ph]);
			idle_on = (ph != 4);
			for (int j = 0; j < PHASE_ITEMS; j++) begin
				issue(random_command(), pushed);
				maybe_pause();
				// hold off until the block has emptied
				if (ph == 1 && j == 29)
					drain();
			end
		end
		drain();

		if (bad_words == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== led_matrix_frame_refresh_unit.f =====
rtl/core/lmfr_pkg.sv
rtl/core/lmfr_front.sv
rtl/core/lmfr_queue.sv
rtl/core/lmfr_back.sv
rtl/core/led_matrix_frame_refresh_unit.sv
verif/testbench.sv
